// ===== rtl/best_worst_fit_page_allocator_defines.svh =====
`ifndef BEST_WORST_FIT_PAGE_ALLOCATOR_DEFINES_SVH
`define BEST_WORST_FIT_PAGE_ALLOCATOR_DEFINES_SVH

// Combinational implication checked at every clock edge out of reset.
`define BWFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BWFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bwfa_pkg.sv =====
package bwfa_pkg;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_NOID   = 2'd2;
    localparam logic [1:0] ST_ZERO   = 2'd3;

    // width of a request in pages before it is checked against the memory
    localparam int NEED_W = 9;

    typedef struct packed {
        logic sh_up;
        logic sh_dn;
        logic wr;
    } cell_op_t;

endpackage

// ===== rtl/bwfa_cell.sv =====
module bwfa_cell #(
    parameter int TOTAL_PAGES = 32,
    parameter int ID_BITS     = 8,
    parameter int CELL_IDX    = 0
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  bwfa_pkg::cell_op_t                            op,
    input  logic [$clog2(TOTAL_PAGES)-1:0]                idx,
    input  logic [$clog2(TOTAL_PAGES)-1:0]                widx,
    input  logic [ID_BITS+$clog2(TOTAL_PAGES+1):0]        wdata,
    input  logic [ID_BITS+$clog2(TOTAL_PAGES+1):0]        left,
    input  logic [ID_BITS+$clog2(TOTAL_PAGES+1):0]        right,
    output logic [ID_BITS+$clog2(TOTAL_PAGES+1):0]        q
);

    localparam int SZ_W  = $clog2(TOTAL_PAGES + 1);
    localparam int IDX_W = $clog2(TOTAL_PAGES);
    localparam int EW    = 1 + ID_BITS + SZ_W;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [EW-1:0] RST_VAL =
        (CELL_IDX == 0) ? {1'b1, ID_BITS'(0), SZ_W'(TOTAL_PAGES)} : EW'(0);

    logic [EW-1:0] q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= RST_VAL;
        end
        else if (op.wr && widx == MY_IDX)
        begin
            q_reg <= wdata;
        end
        else if (op.sh_up && MY_IDX > idx)
        begin
            q_reg <= left;
        end
        else if (op.sh_dn && MY_IDX >= idx)
        begin
            q_reg <= right;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/best_worst_fit_page_allocator.sv =====
// Segment allocator over TOTAL_PAGES pages of PAGE_KB KB each.
// Input channel: in_valid/in_stall with cmd, prog_id, request_kb; a beat is
// taken when in_valid is high and in_stall low. cmd 0 allocates, 1 frees
// the lowest segment owned by prog_id, anything else queries.
// Output channel: out_valid/out_stall with status, start_page, pages,
// free_fragments; exactly one beat per input beat, in order.
// fit_mode is written by cfg_we/cfg_wdata: 0 best, 1 worst fit. The user
// must write it only while idle; the block itself does not enforce it. One
// command at a time; a query skips the scan. The scan reads one cell of
// the segment chain per cycle. Splits and merges move the chain by one
// cell per cycle.
// A finished result sits in the output register while the block stays
// free for the next beat; a result that finds that register still stalled
// waits until it drains, and in_stall stays high meanwhile.
// Reset: one free segment covering all pages, fit_mode best fit, no
// result pending. No clearing pass is needed.
module best_worst_fit_page_allocator #(
    parameter int TOTAL_PAGES = 32,
    parameter int PAGE_KB     = 4,
    parameter int ID_BITS     = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] prog_id,
    input  logic [7:0] request_kb,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [4:0] start_page,
    output logic [5:0] pages,
    output logic [4:0] free_fragments
);

    localparam int SZ_W   = $clog2(TOTAL_PAGES + 1);
    localparam int IDX_W  = $clog2(TOTAL_PAGES);
    localparam int CNT_W  = $clog2(TOTAL_PAGES + 1);
    localparam int EW     = 1 + ID_BITS + SZ_W;
    localparam int NW     = bwfa_pkg::NEED_W;
    localparam int RCP_SH = 17;
    localparam int RCP_W  = 18;
    localparam int RCP_M  = (2 ** RCP_SH + PAGE_KB - 1) / PAGE_KB;
    localparam int PW     = NW + RCP_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_NEXT   = 6'b000100,
        S_APPLY  = 6'b001000,
        S_APPLY2 = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next;
    logic             fit_mode_reg;
    logic             out_valid_reg, out_valid_next;

    logic [1:0]         cmd_reg, cmd_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [NW-1:0]      need_reg, need_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [SZ_W-1:0]    run_reg, run_next;
    logic               found_reg, found_next;
    logic [SZ_W-1:0]    best_reg, best_next;
    logic [IDX_W-1:0]   pick_reg, pick_next;
    logic [SZ_W-1:0]    pstart_reg, pstart_next;
    logic               prev_free_reg, prev_free_next;
    logic [SZ_W-1:0]    prev_size_reg, prev_size_next;
    logic [SZ_W-1:0]    cur_size_reg, cur_size_next;
    logic [1:0]         rstat_reg, rstat_next;
    logic [SZ_W-1:0]    rstart_reg, rstart_next;
    logic [NW-1:0]      rpages_reg, rpages_next;

    logic [1:0] status_reg;
    logic [4:0] start_page_reg;
    logic [5:0] pages_reg;
    logic [4:0] free_fragments_reg;

    // segment chain
    logic [EW-1:0]      ent [TOTAL_PAGES];
    bwfa_pkg::cell_op_t op;
    logic [IDX_W-1:0]   op_idx;
    logic [IDX_W-1:0]   op_widx;
    logic [EW-1:0]      op_wdata;

    genvar g;
    generate
        for (g = 0; g < TOTAL_PAGES; g++)
        begin : g_cell
            logic [EW-1:0] lft;
            logic [EW-1:0] rgt;
            if (g == 0)
            begin : g_first
                assign lft = '0;
            end
            else
            begin : g_mid_l
                assign lft = ent[g-1];
            end
            if (g == TOTAL_PAGES - 1)
            begin : g_last
                assign rgt = '0;
            end
            else
            begin : g_mid_r
                assign rgt = ent[g+1];
            end
            bwfa_cell #(
                .TOTAL_PAGES(TOTAL_PAGES),
                .ID_BITS    (ID_BITS),
                .CELL_IDX   (g)
            ) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .op   (op),
                .idx  (op_idx),
                .widx (op_widx),
                .wdata(op_wdata),
                .left (lft),
                .right(rgt),
                .q    (ent[g])
            );
        end
    endgenerate

    // pages needed: ceil(kb / PAGE_KB) by reciprocal multiply
    logic [NW-1:0] kb_sum;
    logic [PW-1:0] need_prod;
    logic [NW-1:0] need_calc;

    assign kb_sum    = NW'(request_kb) + NW'(PAGE_KB - 1);
    assign need_prod = PW'(kb_sum) * PW'(RCP_M);
    assign need_calc = need_prod[RCP_SH +: NW];

    // read port into the chain
    logic [IDX_W-1:0]   rd_idx;
    logic [EW-1:0]      rd;
    logic               rd_free;
    logic [ID_BITS-1:0] rd_owner;
    logic [SZ_W-1:0]    rd_size;
    logic [IDX_W-1:0]   pick_inc;

    assign pick_inc = pick_reg + IDX_W'(1);
    assign rd_idx   = (state_reg == S_NEXT) ? pick_inc : scan_reg[IDX_W-1:0];
    assign rd       = ent[rd_idx];
    assign rd_free  = rd[EW-1];
    assign rd_owner = rd[EW-2:SZ_W];
    assign rd_size  = rd[SZ_W-1:0];

    logic            cand;
    logic            nxt_ok;
    logic            nm;
    logic            pm;
    logic [SZ_W+1:0] merge_sum;
    logic            split;

    assign split  = (NW'(best_reg) != need_reg);
    assign nxt_ok = (CNT_W'(pick_reg) + CNT_W'(1)) < count_reg;
    assign nm     = nxt_ok && rd_free;
    assign pm     = (pick_reg != '0) && prev_free_reg;
    assign merge_sum = (pm ? (SZ_W+2)'(prev_size_reg) : '0) + (SZ_W+2)'(cur_size_reg)
                     + (nm ? (SZ_W+2)'(rd_size) : '0);

    always_comb
    begin
        if (fit_mode_reg)
        begin
            cand = rd_free && (!found_reg || rd_size > best_reg);
        end
        else
        begin
            cand = rd_free && (NW'(rd_size) >= need_reg)
                && (!found_reg || rd_size < best_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        fcnt_next      = fcnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        need_next      = need_reg;
        scan_next      = scan_reg;
        run_next       = run_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        pstart_next    = pstart_reg;
        prev_free_next = prev_free_reg;
        prev_size_next = prev_size_reg;
        cur_size_next  = cur_size_reg;
        rstat_next     = rstat_reg;
        rstart_next    = rstart_reg;
        rpages_next    = rpages_reg;
        op             = '0;
        op_idx         = pick_reg;
        op_widx        = pick_reg;
        op_wdata       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = cmd;
                    id_next        = ID_BITS'(prog_id);
                    need_next      = need_calc;
                    scan_next      = '0;
                    run_next       = '0;
                    found_next     = 1'b0;
                    prev_free_next = 1'b0;
                    rstat_next     = bwfa_pkg::ST_OK;
                    rstart_next    = '0;
                    rpages_next    = '0;
                    if (cmd == bwfa_pkg::CMD_ALLOC || cmd == bwfa_pkg::CMD_FREE)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_reg == count_reg)
                begin
                    state_next = S_OUT;
                    if (cmd_reg == bwfa_pkg::CMD_FREE)
                    begin
                        rstat_next = bwfa_pkg::ST_NOID;
                    end
                    else if (need_reg == '0)
                    begin
                        rstat_next = bwfa_pkg::ST_ZERO;
                    end
                    else if (!found_reg || NW'(best_reg) < need_reg)
                    begin
                        rstat_next = bwfa_pkg::ST_NOFIT;
                    end
                    else if (split && count_reg == CNT_W'(TOTAL_PAGES))
                    begin
                        rstat_next = bwfa_pkg::ST_NOFIT;
                    end
                    else
                    begin
                        state_next = S_APPLY;
                    end
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                    run_next  = run_reg + rd_size;
                    if (cmd_reg == bwfa_pkg::CMD_FREE)
                    begin
                        if (!rd_free && rd_owner == id_reg)
                        begin
                            pick_next     = scan_reg[IDX_W-1:0];
                            pstart_next   = run_reg;
                            cur_size_next = rd_size;
                            state_next    = S_NEXT;
                        end
                        else
                        begin
                            prev_free_next = rd_free;
                            prev_size_next = rd_size;
                        end
                    end
                    else if (cand)
                    begin
                        found_next  = 1'b1;
                        best_next   = rd_size;
                        pick_next   = scan_reg[IDX_W-1:0];
                        pstart_next = run_reg;
                    end
                end
            end
            S_NEXT:
            begin
                rstart_next = pstart_reg;
                rpages_next = NW'(cur_size_reg);
                op.wr       = 1'b1;
                op_wdata    = {1'b1, ID_BITS'(0), SZ_W'(merge_sum)};
                state_next  = S_OUT;
                if (pm)
                begin
                    // fold into the free segment below, drop this entry
                    op_widx    = pick_reg - IDX_W'(1);
                    op.sh_dn   = 1'b1;
                    op_idx     = pick_reg;
                    count_next = count_reg - CNT_W'(1);
                    if (nm)
                    begin
                        fcnt_next  = fcnt_reg - CNT_W'(1);
                        state_next = S_APPLY2;
                    end
                end
                else
                begin
                    op_widx    = pick_reg;
                    op.sh_dn   = nm;
                    op_idx     = pick_inc;
                    count_next = count_reg - CNT_W'(nm);
                    fcnt_next  = fcnt_reg + CNT_W'(!nm);
                end
            end
            S_APPLY:
            begin
                rstart_next = pstart_reg;
                rpages_next = need_reg;
                op.wr       = 1'b1;
                op_widx     = pick_reg;
                op_wdata    = {1'b0, id_reg, need_reg[SZ_W-1:0]};
                op.sh_up    = split;
                op_idx      = pick_reg;
                if (split)
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_APPLY2;
                end
                else
                begin
                    fcnt_next  = fcnt_reg - CNT_W'(1);
                    state_next = S_OUT;
                end
            end
            S_APPLY2:
            begin
                if (cmd_reg == bwfa_pkg::CMD_ALLOC)
                begin
                    // remainder of the split stays free just above
                    op.wr    = 1'b1;
                    op_widx  = pick_inc;
                    op_wdata = {1'b1, ID_BITS'(0), SZ_W'(best_reg - need_reg[SZ_W-1:0])};
                end
                else
                begin
                    op.sh_dn   = 1'b1;
                    op_idx     = pick_reg;
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(1);
            fcnt_reg      <= CNT_W'(1);
            fit_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fcnt_reg      <= fcnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                fit_mode_reg <= cfg_wdata;
            end
        end
    end

    logic [15:0] start_wide;
    logic [15:0] pages_wide;
    logic [15:0] fcnt_wide;

    assign start_wide = 16'(rstart_reg);
    assign pages_wide = 16'(rpages_reg);
    assign fcnt_wide  = 16'(fcnt_reg);

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        need_reg      <= need_next;
        scan_reg      <= scan_next;
        run_reg       <= run_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        pick_reg      <= pick_next;
        pstart_reg    <= pstart_next;
        prev_free_reg <= prev_free_next;
        prev_size_reg <= prev_size_next;
        cur_size_reg  <= cur_size_next;
        rstat_reg     <= rstat_next;
        rstart_reg    <= rstart_next;
        rpages_reg    <= rpages_next;
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            status_reg         <= rstat_reg;
            start_page_reg     <= start_wide[4:0];
            pages_reg          <= pages_wide[5:0];
            free_fragments_reg <= fcnt_wide[4:0];
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign start_page     = start_page_reg;
    assign pages          = pages_reg;
    assign free_fragments = free_fragments_reg;

endmodule

// ===== rtl/bwfa_checker.sv =====
`include "best_worst_fit_page_allocator_defines.svh"

module bwfa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [4:0] start_page,
    input logic [5:0] pages
);

    // a stalled result beat holds
    `BWFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(status) && $stable(start_page) && $stable(pages),
        "stalled result beat changed")

    // block goes busy right after taking a command
    `BWFA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "accept not followed by busy")

    // refused commands report no pages
    `BWFA_ASSERT_NOW(a_fail_zero, out_valid && status != bwfa_pkg::ST_OK,
        pages == 6'd0 && start_page == 5'd0, "failure with nonzero fields")

    // a zero-size refusal never claims pages
    `BWFA_ASSERT_NOW(a_zero_status, out_valid && status == bwfa_pkg::ST_ZERO,
        pages == 6'd0, "zero-size refusal with pages")

endmodule

bind best_worst_fit_page_allocator bwfa_checker u_bwfa_checker (.*);

// ===== verif/testbench.sv =====
module testbench;

    localparam int NUM_PAGES = 32;
    localparam int KB_PER_PAGE = 4;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [1:0] status;
        logic [4:0] start_page;
        logic [5:0] pages;
        logic [4:0] free_fragments;
    } alloc_result_t;

    class alloc_scoreboard;
        bit          seg_free[NUM_PAGES];
        int unsigned seg_owner[NUM_PAGES];
        int unsigned seg_size[NUM_PAGES];
        int unsigned seg_count;
        bit          largest_first;
        alloc_result_t pending[$];
        int unsigned errors;

        function void clear();
            foreach (seg_free[i])
            begin
                seg_free[i] = 0;
                seg_owner[i] = 0;
                seg_size[i] = 0;
            end
            seg_free[0] = 1;
            seg_size[0] = NUM_PAGES;
            seg_count = 1;
            largest_first = 0;
            errors = 0;
        endfunction

        function int unsigned free_count();
            int unsigned n;
            n = 0;
            for (int i = 0; i < seg_count; i++)
                if (seg_free[i])
                    n++;
            return n;
        endfunction

        function int unsigned page_of(int unsigned idx);
            int unsigned s;
            s = 0;
            for (int i = 0; i < idx; i++)
                s += seg_size[i];
            return s;
        endfunction

        function void drop(int unsigned idx);
            for (int i = idx; i + 1 < seg_count; i++)
            begin
                seg_free[i] = seg_free[i + 1];
                seg_owner[i] = seg_owner[i + 1];
                seg_size[i] = seg_size[i + 1];
            end
            seg_count--;
        endfunction

        function void note_input(logic [1:0] c, logic [7:0] id, logic [7:0] kb);
            alloc_result_t r;
            int unsigned need, pick, best, i;
            bit found;
            r.status = bwfa_pkg::ST_OK;
            r.start_page = 0;
            r.pages = 0;
            if (c == bwfa_pkg::CMD_ALLOC)
            begin
                need = (kb + KB_PER_PAGE - 1) / KB_PER_PAGE;
                found = 0;
                pick = 0;
                best = 0;
                for (i = 0; i < seg_count; i++)
                begin
                    if (!seg_free[i])
                        continue;
                    if (!largest_first)
                    begin
                        if (seg_size[i] >= need && (!found || seg_size[i] < best))
                        begin
                            best = seg_size[i];
                            pick = i;
                            found = 1;
                        end
                    end
                    else if (!found || seg_size[i] > best)
                    begin
                        best = seg_size[i];
                        pick = i;
                        found = 1;
                    end
                end
                if (need == 0)
                    r.status = bwfa_pkg::ST_ZERO;
                else if (!found || best < need
                         || (best != need && seg_count >= NUM_PAGES))
                    r.status = bwfa_pkg::ST_NOFIT;
                else
                begin
                    if (best != need)
                    begin
                        for (i = seg_count; i > pick; i--)
                        begin
                            seg_free[i] = seg_free[i - 1];
                            seg_owner[i] = seg_owner[i - 1];
                            seg_size[i] = seg_size[i - 1];
                        end
                        seg_count++;
                        seg_size[pick + 1] = best - need;
                    end
                    seg_free[pick] = 0;
                    seg_owner[pick] = id;
                    seg_size[pick] = need;
                    r.start_page = 5'(page_of(pick));
                    r.pages = 6'(need);
                end
            end
            else if (c == bwfa_pkg::CMD_FREE)
            begin
                for (i = 0; i < seg_count; i++)
                    if (!seg_free[i] && seg_owner[i] == id)
                        break;
                if (i >= seg_count)
                    r.status = bwfa_pkg::ST_NOID;
                else
                begin
                    r.start_page = 5'(page_of(i));
                    r.pages = 6'(seg_size[i]);
                    seg_free[i] = 1;
                    seg_owner[i] = 0;
                    if (i + 1 < seg_count && seg_free[i + 1])
                    begin
                        seg_size[i] += seg_size[i + 1];
                        drop(i + 1);
                    end
                    if (i > 0 && seg_free[i - 1])
                    begin
                        seg_size[i - 1] += seg_size[i];
                        drop(i);
                    end
                end
            end
            r.free_fragments = 5'(free_count());
            pending.push_back(r);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $display("%0t status: expected %0d actual %0d", $time, e.status, got.status);
                errors++;
            end
            if (got.start_page !== e.start_page)
            begin
                $display("%0t start_page: expected %0d actual %0d", $time, e.start_page,
                         got.start_page);
                errors++;
            end
            if (got.pages !== e.pages)
            begin
                $display("%0t pages: expected %0d actual %0d", $time, e.pages, got.pages);
                errors++;
            end
            if (got.free_fragments !== e.free_fragments)
            begin
                $display("%0t free_fragments: expected %0d actual %0d", $time,
                         e.free_fragments, got.free_fragments);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_wdata = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [1:0] cmd = 0;
    logic [7:0] prog_id = 0;
    logic [7:0] request_kb = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [1:0] status;
    logic [4:0] start_page;
    logic [5:0] pages;
    logic [4:0] free_fragments;

    alloc_scoreboard sb = new();
    bit long_hold = 0;
    bit drain_fast = 0;

    best_worst_fit_page_allocator DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .prog_id(prog_id),
        .request_kb(request_kb), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .start_page(start_page), .pages(pages),
        .free_fragments(free_fragments)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // receiver: random stall pattern, calm stretches, one long hold
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{status, start_page, pages, free_fragments});
        if (long_hold)
            out_stall <= 1;
        else if (drain_fast)
            out_stall <= 0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    initial
    begin
        @(posedge clk);
        wait (rst_n);
        repeat (300) @(posedge clk);
        long_hold = 1;
        repeat (600) @(posedge clk);
        long_hold = 0;
    end

    int burst_left = 0;

    // one beat; gap handling lives here so valid stays high inside a burst
    task automatic send_beat(logic [1:0] c, logic [7:0] id, logic [7:0] kb);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 40);
            if (gap != 0)
            begin
                in_valid <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        in_valid <= 1;
        cmd <= c;
        prog_id <= id;
        request_kb <= kb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(c, id, kb);
        burst_left--;
    endtask

    task automatic drain_and_set(bit mode);
        in_valid <= 0;
        burst_left = 0;
        drain_fast = 1;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 0;
        sb.largest_first = mode;
        drain_fast = 0;
    endtask

    task automatic random_item(int unsigned nids);
        int unsigned k;
        logic [7:0] id;
        k = $urandom_range(0, 99);
        id = 8'($urandom_range(0, nids - 1));
        if (k < 3)
            id = 8'($urandom);
        if (k < 50)
            send_beat(bwfa_pkg::CMD_ALLOC, id,
                      8'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 24)));
        else if (k < 90)
            send_beat(bwfa_pkg::CMD_FREE, id, 8'($urandom));
        else
            send_beat($urandom_range(0, 1) ? CMD_QUERY : CMD_SPARE, id, 8'($urandom));
    endtask

    initial
    begin
        sb.clear();
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: zero size, rounding, full fit, refusal, merges, frees
        send_beat(bwfa_pkg::CMD_ALLOC, 8'd1, 8'd0);
        send_beat(bwfa_pkg::CMD_ALLOC, 8'd1, 8'd1);
        send_beat(bwfa_pkg::CMD_ALLOC, 8'd2, 8'd4);
        send_beat(bwfa_pkg::CMD_ALLOC, 8'd3, 8'd5);
        send_beat(bwfa_pkg::CMD_ALLOC, 8'd255, 8'd255);
        send_beat(bwfa_pkg::CMD_FREE, 8'd7, 8'd0);
        send_beat(bwfa_pkg::CMD_FREE, 8'd2, 8'd0);
        send_beat(bwfa_pkg::CMD_FREE, 8'd1, 8'd0);
        send_beat(bwfa_pkg::CMD_FREE, 8'd3, 8'd0);
        send_beat(CMD_QUERY, 8'hff, 8'hff);
        send_beat(CMD_SPARE, 8'h00, 8'h00);
        send_beat(bwfa_pkg::CMD_ALLOC, 8'd9, 8'd128);
        send_beat(bwfa_pkg::CMD_ALLOC, 8'd10, 8'd129);
        send_beat(bwfa_pkg::CMD_FREE, 8'd9, 8'd0);
        drain_and_set(1);
        send_beat(bwfa_pkg::CMD_ALLOC, 8'd4, 8'd8);
        send_beat(bwfa_pkg::CMD_ALLOC, 8'd5, 8'd12);
        send_beat(bwfa_pkg::CMD_FREE, 8'd4, 8'd0);
        send_beat(bwfa_pkg::CMD_ALLOC, 8'd6, 8'd4);
        send_beat(bwfa_pkg::CMD_FREE, 8'd5, 8'd0);
        send_beat(bwfa_pkg::CMD_FREE, 8'd6, 8'd0);
        for (int i = 0; i < 33; i++)
            send_beat(bwfa_pkg::CMD_ALLOC, 8'd20, 8'd4);
        for (int i = 0; i < 33; i++)
            send_beat(bwfa_pkg::CMD_FREE, 8'd20, 8'd0);
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_and_set(ph[0]);
            for (int n = 0; n < 250; n++)
                random_item((ph < 3) ? 6 : 256);
        end
        drain_and_set(0);
        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("testbench: errors");
        $finish;
    end
endmodule
